@@ hdl/mdet_pkg.sv @@
// ----------------------------------------------------------------------------
// mdet_pkg
// Shared types and constants for the matrix determinant block.
// ----------------------------------------------------------------------------
package mdet_pkg;

  localparam int DATA_W = 16;
  localparam int CFG_W  = 4;

  localparam logic [CFG_W-1:0] ORDER_RESET = 4'd2;

  typedef logic [DATA_W-1:0] word_t;

  // tags that travel with each product through the shared unit
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

@@ hdl/mdet_ram.sv @@
// ----------------------------------------------------------------------------
// mdet_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mdet_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/mdet_mac.sv @@
// ----------------------------------------------------------------------------
// mdet_mac
// Shared multiply-accumulate unit, modulo 2^16: a product register then an
// accumulator; a dot product ends on the word tagged last.
// ----------------------------------------------------------------------------
module mdet_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  mdet_pkg::mac_ctl_t ctl,
  input  mdet_pkg::word_t   coef,
  input  mdet_pkg::word_t   data,
  output logic              res_vld,
  output mdet_pkg::word_t   res
);
  import mdet_pkg::*;

  logic [2*DATA_W-1:0] full;
  word_t               prod_r;
  word_t               acc_r;
  mac_ctl_t            ctl_r;
  word_t               sum;

  assign full = coef * data;
  assign sum  = (ctl_r.first ? '0 : acc_r) + prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
    prod_r <= full[DATA_W-1:0];
    if (ctl_r.vld) begin
      acc_r <= sum;
    end
  end

  assign res_vld = ctl_r.vld & ctl_r.last;
  assign res     = sum;

endmodule

@@ hdl/int16_matrix_determinant.sv @@
// ----------------------------------------------------------------------------
// int16_matrix_determinant
// Collects a square matrix word by word and computes its determinant mod 2^16
// with a division-free iteration on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// loading: one word per cycle, no stall while idle
// compute after last word: one product per cycle through the mac while in the
//   multiply state, paused for the row load and drain between rows
// one matrix at a time; input stalls during compute and until result is taken
// reset (synchronous, rst_n low) clears the word counter, sequencer and order (to 2)
module int16_matrix_determinant #(
  parameter int MAX_ORDER = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [mdet_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [mdet_pkg::DATA_W-1:0] in_entry_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [mdet_pkg::DATA_W-1:0] out_determinant
);
  import mdet_pkg::*;

  localparam int DEPTH  = MAX_ORDER * MAX_ORDER;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ORD_W  = $clog2(MAX_ORDER + 1);
  localparam int IDX_W  = $clog2(MAX_ORDER);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_LOADW, S_MAC, S_DRAIN, S_FIN_RD, S_FIN_WAIT, S_OUT
  } state_t;

  state_t              state_r;
  logic [CFG_W-1:0]    order_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [ORD_W-1:0]    n_r;
  logic [ORD_W-1:0]    step_r;
  logic [IDX_W-1:0]    i_r, k_r, j_r;
  logic [ADDR_W-1:0]   base_r, aaddr_r;
  word_t               tail_r;
  word_t               row_r [MAX_ORDER];
  logic                ld_vld_r;
  logic [IDX_W-1:0]    ld_k_r;
  logic                drain_r;
  mac_ctl_t            ctl_d1_r;
  logic [IDX_W-1:0]    k_d1_r, j_d1_r, j_d2_r;
  logic                out_valid_r;
  word_t               det_r;

  logic [ORD_W-1:0]    n_eff;
  logic [CNT_W-1:0]    total;
  logic [CNT_W-1:0]    cnt_inc;
  logic                accept, done, store_en;
  logic [IDX_W-1:0]    nm1;
  logic [ADDR_W-1:0]   n_a, last_base;

  word_t               x_rdata, a_rdata, mac_res;
  logic                x_we, mac_vld;
  logic [ADDR_W-1:0]   x_waddr, x_raddr;
  word_t               x_wdata;
  mac_ctl_t            ctl_issue;

  // effective order: zero means one, above the store size saturates
  always_comb begin
    if (order_r == '0) begin
      n_eff = ORD_W'(1);
    end else if (32'(order_r) > MAX_ORDER) begin
      n_eff = ORD_W'(MAX_ORDER);
    end else begin
      n_eff = ORD_W'(order_r);
    end
  end

  assign total    = CNT_W'(n_eff) * CNT_W'(n_eff);
  assign store_en = (32'(cnt_r) < DEPTH);
  assign cnt_inc  = store_en ? cnt_r + CNT_W'(1) : cnt_r;
  assign accept   = in_valid & ~in_stall;
  assign done     = (cnt_inc >= total);
  assign in_stall = (state_r != S_IDLE);

  assign nm1       = IDX_W'(n_r - ORD_W'(1));
  assign n_a       = ADDR_W'(n_r);
  assign last_base = ADDR_W'(CNT_W'(n_r) * CNT_W'(n_r) - CNT_W'(n_r));

  // x store: holds the matrix, then the working rows of each iteration
  always_comb begin
    if (state_r == S_IDLE) begin
      x_we    = accept & store_en;
      x_waddr = ADDR_W'(cnt_r);
      x_wdata = word_t'(in_entry_value);
    end else begin
      x_we    = mac_vld;
      x_waddr = base_r + ADDR_W'(j_d2_r);
      x_wdata = mac_res;
    end
    x_raddr = (state_r == S_FIN_RD) ? '0 : base_r + ADDR_W'(k_r);
  end

  mdet_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (x_waddr),
    .wdata (x_wdata),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  // a store: the original matrix, read column-wise by the mac
  mdet_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (state_r == S_IDLE && accept && store_en),
    .waddr (ADDR_W'(cnt_r)),
    .wdata (word_t'(in_entry_value)),
    .raddr (aaddr_r),
    .rdata (a_rdata)
  );

  assign ctl_issue.vld   = (state_r == S_MAC);
  assign ctl_issue.first = (k_r == i_r);
  assign ctl_issue.last  = (k_r == nm1);

  mdet_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_d1_r),
    .coef    (row_r[k_d1_r]),
    .data    (a_rdata),
    .res_vld (mac_vld),
    .res     (mac_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      order_r     <= ORDER_RESET;
      cnt_r       <= '0;
      ld_vld_r    <= 1'b0;
      ctl_d1_r    <= '0;
      out_valid_r <= 1'b0;
      drain_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_r <= cfg_data;
      end
      ctl_d1_r <= ctl_issue;
      ld_vld_r <= (state_r == S_LOAD);

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (done) begin
              cnt_r <= '0;
              n_r   <= n_eff;
              if (n_eff == ORD_W'(1)) begin
                state_r <= S_FIN_RD;
              end else begin
                step_r  <= ORD_W'(1);
                i_r     <= IDX_W'(n_eff - ORD_W'(1));
                k_r     <= IDX_W'(n_eff - ORD_W'(1));
                base_r  <= ADDR_W'(total - CNT_W'(n_eff));
                tail_r  <= '0;
                state_r <= S_LOAD;
              end
            end else begin
              cnt_r <= cnt_inc;
            end
          end
        end
        S_LOAD: begin
          if (k_r == nm1) begin
            state_r <= S_LOADW;
          end else begin
            k_r <= k_r + IDX_W'(1);
          end
        end
        S_LOADW: begin
          j_r     <= '0;
          k_r     <= i_r;
          aaddr_r <= base_r;
          state_r <= S_MAC;
        end
        S_MAC: begin
          if (k_r == nm1) begin
            if (j_r == nm1) begin
              drain_r <= 1'b0;
              state_r <= S_DRAIN;
            end else begin
              j_r     <= j_r + IDX_W'(1);
              k_r     <= i_r;
              aaddr_r <= base_r + ADDR_W'(j_r) + ADDR_W'(1);
            end
          end else begin
            k_r     <= k_r + IDX_W'(1);
            aaddr_r <= aaddr_r + n_a;
          end
        end
        S_DRAIN: begin
          drain_r <= 1'b1;
          if (drain_r) begin
            if (i_r == '0) begin
              if (step_r == ORD_W'(nm1)) begin
                state_r <= S_FIN_RD;
              end else begin
                step_r  <= step_r + ORD_W'(1);
                i_r     <= nm1;
                k_r     <= nm1;
                base_r  <= last_base;
                tail_r  <= '0;
                state_r <= S_LOAD;
              end
            end else begin
              i_r     <= i_r - IDX_W'(1);
              k_r     <= i_r - IDX_W'(1);
              base_r  <= base_r - n_a;
              state_r <= S_LOAD;
            end
          end
        end
        S_FIN_RD: begin
          state_r <= S_FIN_WAIT;
        end
        S_FIN_WAIT: begin
          // sign of the iteration result flips for even orders
          det_r       <= nm1[0] ? word_t'(16'd0 - x_rdata) : x_rdata;
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // row capture: diagonal takes minus the sum of lower diagonals
      if (ld_vld_r) begin
        if (ld_k_r == i_r) begin
          row_r[ld_k_r] <= word_t'(16'd0 - tail_r);
          tail_r        <= tail_r + x_rdata;
        end else begin
          row_r[ld_k_r] <= x_rdata;
        end
      end
    end
    ld_k_r <= k_r;
    k_d1_r <= k_r;
    j_d1_r <= j_r;
    j_d2_r <= j_d1_r;
  end

  assign out_valid       = out_valid_r;
  assign out_determinant = det_r;

endmodule

@@ dv/tb_int16_matrix_determinant.sv @@
// ----------------------------------------------------------------------------
// tb_int16_matrix_determinant
// Loads square matrices word by word under random idling and stalls, predicts
// each determinant mod 2^16 with its own division-free computation, and checks
// every result word in order against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_int16_matrix_determinant;
  import mdet_pkg::*;

  localparam int MAX_N = 8;
  localparam int STORE_N = MAX_N * MAX_N;
  localparam int STALL_LIMIT = 40000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [DATA_W-1:0] in_entry_value;
  logic out_valid;
  logic out_stall;
  logic signed [DATA_W-1:0] out_determinant;

  // predictor state
  word_t entry_mem[STORE_N];
  int unsigned fill_cnt;
  logic [CFG_W-1:0] order_reg;
  word_t det_q[$];

  int errors;
  int idle_cycles;
  int stall_pct;
  int burst_left;
  int sent_words;

  int16_matrix_determinant #(.MAX_ORDER(MAX_N)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_entry_value(in_entry_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_determinant(out_determinant)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int eff_order();
    int n;
    n = order_reg;
    if (n < 1) n = 1;
    if (n > MAX_N) n = MAX_N;
    return n;
  endfunction

  // division-free determinant, everything kept mod 2^16
  function automatic word_t bird_det(int n);
    word_t x[MAX_N][MAX_N];
    word_t m[MAX_N][MAX_N];
    word_t tail;
    word_t acc;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        x[i][j] = entry_mem[i*n + j];
    for (int s = 1; s < n; s++) begin
      tail = '0;
      for (int i = n - 1; i >= 0; i--) begin
        for (int j = 0; j < n; j++)
          m[i][j] = (j > i) ? x[i][j] : '0;
        m[i][i] = -tail;
        tail = tail + x[i][i];
      end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          acc = '0;
          for (int k = i; k < n; k++)
            acc = acc + word_t'(m[i][k] * entry_mem[k*n + j]);
          x[i][j] = acc;
        end
    end
    return ((n - 1) & 1) ? word_t'(-x[0][0]) : x[0][0];
  endfunction

  function automatic void absorb_word(word_t v);
    int n;
    n = eff_order();
    if (fill_cnt < STORE_N) begin
      entry_mem[fill_cnt] = v;
      fill_cnt++;
    end
    if (fill_cnt >= n * n) begin
      fill_cnt = 0;
      det_q.push_back(bird_det(n));
    end
  endfunction

  // one word through the input channel, then maybe a gap
  task automatic send_word(word_t v);
    int gap;
    in_valid <= 1'b1;
    in_entry_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_word(v);
    sent_words++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (det_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_order(logic [CFG_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    order_reg = v;
  endtask

  function automatic word_t rand_entry();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom_range(0, 2) == 0 ? 16'h8000 : 16'h7fff);
      1, 2: return word_t'($urandom_range(0, 6) - 3);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic send_matrix(int n);
    for (int i = 0; i < n * n; i++) send_word(rand_entry());
  endtask

  // default order 2 right after reset, with extreme entries
  task automatic test_reset_order();
    send_word(16'h7fff); send_word(16'h8000); send_word(16'hffff); send_word(16'h0001);
    send_word(16'h8000); send_word(16'h8000); send_word(16'h8000); send_word(16'h7fff);
  endtask

  task automatic test_order_zero();
    set_order(4'd0);
    send_word(16'h8000);
    send_word(16'h5a5a);
    set_order(4'd1);
    send_word(16'h7fff);
  endtask

  task automatic test_order_three();
    set_order(4'd3);
    send_word(16'd2); send_word(16'hffff); send_word(16'd0);
    send_word(16'hffff); send_word(16'd2); send_word(16'hffff);
    send_word(16'd0); send_word(16'hffff); send_word(16'd2);
  endtask

  // order dropped mid-load: the next word completes on the smaller order
  task automatic test_order_lowered();
    set_order(4'd3);
    for (int i = 0; i < 5; i++) send_word(rand_entry());
    set_order(4'd2);
    send_word(16'h1234);
  endtask

  // codes above the limit saturate to the largest order
  task automatic test_order_saturated();
    set_order(4'd15);
    send_matrix(MAX_N);
    set_order(4'd9);
    send_matrix(MAX_N);
  endtask

  task automatic test_random_matrices();
    int n;
    int reps;
    while (sent_words < 1750) begin
      case ($urandom_range(0, 19))
        0: n = 0;
        1: n = $urandom_range(9, 15);
        2, 3: n = $urandom_range(5, 8);
        default: n = $urandom_range(1, 4);
      endcase
      stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 70);
      set_order(CFG_W'(n));
      reps = $urandom_range(1, 6);
      for (int r = 0; r < reps; r++) send_matrix(eff_order());
      // broken sequence: extra words that may leave a partial load, then a new order
      if ($urandom_range(0, 5) == 0)
        for (int i = $urandom_range(1, 20); i > 0; i--) send_word(rand_entry());
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (det_q.size() == 0) begin
        $display("%0t: unexpected determinant word, expected none, actual %h",
                 $time, out_determinant);
        errors++;
      end else begin
        want = det_q.pop_front();
        if (out_determinant !== want) begin
          $display("%0t: determinant mismatch, expected %h, actual %h",
                   $time, want, out_determinant);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_entry_value = '0;
    out_stall = 1'b0;
    stall_pct = 30;
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    sent_words = 0;
    fill_cnt = 0;
    order_reg = ORDER_RESET;
    foreach (entry_mem[i]) entry_mem[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_order();
    test_order_zero();
    test_order_three();
    test_order_lowered();
    test_order_saturated();
    test_random_matrices();

    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0 && det_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ int16_matrix_determinant.f @@
hdl/mdet_pkg.sv
hdl/mdet_ram.sv
hdl/mdet_mac.sv
hdl/int16_matrix_determinant.sv
dv/tb_int16_matrix_determinant.sv
